>>> sv/md5_pkg.sv
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
  } md5_out_t;

  // Classified command held in the queue between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } md5_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREF,
    ST_ROUND,
    ST_ADD,
    ST_PAD_HEAD,
    ST_PAD_ZERO,
    ST_PAD_LEN0,
    ST_PAD_LEN1,
    ST_EMIT
  } md5_state_t;

  localparam logic [31:0] CHAIN_INIT [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [7:0] PAD_BYTE       = 8'h80;
  localparam logic [5:0] LAST_FILL      = 6'd63;
  localparam logic [5:0] TWO_BLOCK_FILL = 6'd56;
  localparam logic [4:0] ZERO_END_ONE   = 5'd14;
  localparam logic [4:0] ZERO_END_TWO   = 5'd16;
  localparam logic [3:0] LEN_WORD_LO    = 4'd14;
  localparam logic [3:0] LEN_WORD_HI    = 4'd15;
  localparam logic [5:0] LAST_ROUND     = 6'd63;

  localparam logic [31:0] K_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TAB [4][4] = '{
    '{5'd7, 5'd12, 5'd17, 5'd22},
    '{5'd5, 5'd9,  5'd14, 5'd20},
    '{5'd4, 5'd11, 5'd16, 5'd23},
    '{5'd6, 5'd10, 5'd15, 5'd21}
  };

  // Message word index used by round r
  function automatic logic [3:0] md5_g(input logic [5:0] r);
    logic [3:0] g;
    unique case (r[5:4])
      2'd0: g = r[3:0];
      2'd1: g = r[3:0] * 4'd5 + 4'd1;
      2'd2: g = r[3:0] * 4'd3 + 4'd5;
      2'd3: g = r[3:0] * 4'd7;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] md5_rotl(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] tmp;
    tmp = {v, v} << n;
    return tmp[63:32];
  endfunction

endpackage

>>> sv/md5_front.sv
module md5_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  md5_pkg::md5_in_t  in_data,
  output logic              q_push,
  output md5_pkg::md5_cmd_t q_cmd,
  input  logic              q_full
);
  import md5_pkg::*;

  logic     hold_v_r, hold_v_nxt;
  md5_cmd_t cmd_r, cmd_nxt;
  logic     take;

  assign in_full = hold_v_r && q_full;
  assign take    = in_push && !in_full;
  assign q_push  = hold_v_r;
  assign q_cmd   = cmd_r;

  always_comb begin
    hold_v_nxt = hold_v_r && q_full;
    cmd_nxt    = cmd_r;
    if (take) begin
      // items with neither a byte nor an end mark do nothing: drop here
      hold_v_nxt       = in_data.byte_valid || in_data.last;
      cmd_nxt.data     = in_data.byte_valid ? in_data.data_byte : 8'h00;
      cmd_nxt.has_byte = in_data.byte_valid;
      cmd_nxt.last     = in_data.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

>>> sv/md5_cmdq.sv
module md5_cmdq #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  md5_pkg::md5_cmd_t din,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output md5_pkg::md5_cmd_t dout
);
  import md5_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  md5_cmd_t        slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign dout    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

>>> sv/md5_back.sv
module md5_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  md5_pkg::md5_cmd_t q_cmd,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output md5_pkg::md5_out_t out_data
);
  import md5_pkg::*;

  md5_state_t  state_r, state_nxt;
  logic [63:0] cnt_r, cnt_nxt;
  logic [31:0] chain_r [4];
  logic [31:0] chain_nxt [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [4:0]  widx_r, widx_nxt;
  logic        last_r, last_nxt;
  logic        two_r, two_nxt;
  logic        lend_r, lend_nxt;
  logic        out_v_r, out_v_nxt;
  md5_out_t    out_r, out_nxt;

  // block buffer: sixteen words, byte-lane writes, registered read
  logic [31:0] blk_mem_r [16];
  logic [31:0] rdata_r;
  logic        mem_we;
  logic [3:0]  mem_be;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [3:0]  mem_raddr;

  logic [31:0] f_val, t_sum, t_rot, t_new;
  logic [63:0] bit_len;
  logic [4:0]  zero_end;
  logic        blk_full;

  assign out_empty = !out_v_r;
  assign out_data  = out_r;
  assign bit_len   = {cnt_r[60:0], 3'b000};
  assign zero_end  = two_r ? ZERO_END_TWO : ZERO_END_ONE;
  assign blk_full  = q_cmd.has_byte && (cnt_r[5:0] == LAST_FILL);

  // one MD5 round
  always_comb begin
    unique case (rnd_r[5:4])
      2'd0: f_val = (b_r & c_r) | (~b_r & d_r);
      2'd1: f_val = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f_val = b_r ^ c_r ^ d_r;
      2'd3: f_val = c_r ^ (b_r | ~d_r);
    endcase
    t_sum = a_r + f_val + rdata_r + K_TAB[rnd_r];
    t_rot = md5_rotl(t_sum, ROT_TAB[rnd_r[5:4]][rnd_r[1:0]]);
    t_new = t_rot + b_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (blk_full) begin
            state_nxt = ST_PREF;
          end else if (q_cmd.last) begin
            state_nxt = ST_PAD_HEAD;
          end
        end
      end
      ST_PREF:     state_nxt = ST_ROUND;
      ST_ROUND:    if (rnd_r == LAST_ROUND) state_nxt = ST_ADD;
      ST_ADD: begin
        priority if (lend_r) begin
          state_nxt = ST_EMIT;
        end else if (two_r) begin
          state_nxt = ST_PAD_ZERO;
        end else if (last_r) begin
          state_nxt = ST_PAD_HEAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD_HEAD: state_nxt = ST_PAD_ZERO;
      ST_PAD_ZERO: begin
        if (widx_r == zero_end) begin
          state_nxt = two_r ? ST_PREF : ST_PAD_LEN0;
        end
      end
      ST_PAD_LEN0: state_nxt = ST_PAD_LEN1;
      ST_PAD_LEN1: state_nxt = ST_PREF;
      ST_EMIT:     if (!out_v_r) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and buffer control
  always_comb begin
    q_pop     = 1'b0;
    cnt_nxt   = cnt_r;
    chain_nxt = chain_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    rnd_nxt   = rnd_r;
    widx_nxt  = widx_r;
    last_nxt  = last_r;
    two_nxt   = two_r;
    lend_nxt  = lend_r;
    out_v_nxt = out_v_r && !out_pop;
    out_nxt   = out_r;
    mem_we    = 1'b0;
    mem_be    = 4'h0;
    mem_waddr = cnt_r[5:2];
    mem_wdata = '0;
    mem_raddr = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          last_nxt = q_cmd.last;
          if (q_cmd.has_byte) begin
            mem_we    = 1'b1;
            mem_be    = 4'b0001 << cnt_r[1:0];
            mem_wdata = {4{q_cmd.data}};
            cnt_nxt   = cnt_r + 64'd1;
          end
        end
      end
      ST_PREF: begin
        mem_raddr = md5_g('0);
        a_nxt     = chain_r[0];
        b_nxt     = chain_r[1];
        c_nxt     = chain_r[2];
        d_nxt     = chain_r[3];
        rnd_nxt   = '0;
      end
      ST_ROUND: begin
        mem_raddr = md5_g(rnd_r + 6'd1);
        a_nxt     = d_r;
        d_nxt     = c_r;
        c_nxt     = b_r;
        b_nxt     = t_new;
        rnd_nxt   = rnd_r + 6'd1;
      end
      ST_ADD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        if (!lend_r && two_r) begin
          two_nxt  = 1'b0;
          widx_nxt = '0;
        end
      end
      ST_PAD_HEAD: begin
        // 0x80 at the fill position, zeros above it in the same word
        mem_we = 1'b1;
        for (int l = 0; l < 4; l++) begin
          mem_be[l]            = (2'(l) >= cnt_r[1:0]);
          mem_wdata[l*8 +: 8]  = (2'(l) == cnt_r[1:0]) ? PAD_BYTE : 8'h00;
        end
        two_nxt  = (cnt_r[5:0] >= TWO_BLOCK_FILL);
        widx_nxt = {1'b0, cnt_r[5:2]} + 5'd1;
      end
      ST_PAD_ZERO: begin
        if (widx_r != zero_end) begin
          mem_we    = 1'b1;
          mem_be    = 4'hf;
          mem_waddr = widx_r[3:0];
          widx_nxt  = widx_r + 5'd1;
        end
      end
      ST_PAD_LEN0: begin
        mem_we    = 1'b1;
        mem_be    = 4'hf;
        mem_waddr = LEN_WORD_LO;
        mem_wdata = bit_len[31:0];
      end
      ST_PAD_LEN1: begin
        mem_we    = 1'b1;
        mem_be    = 4'hf;
        mem_waddr = LEN_WORD_HI;
        mem_wdata = bit_len[63:32];
        lend_nxt  = 1'b1;
      end
      ST_EMIT: begin
        if (!out_v_r) begin
          out_v_nxt        = 1'b1;
          out_nxt.digest_a = chain_r[0];
          out_nxt.digest_b = chain_r[1];
          out_nxt.digest_c = chain_r[2];
          out_nxt.digest_d = chain_r[3];
          chain_nxt        = CHAIN_INIT;
          cnt_nxt          = '0;
          last_nxt         = 1'b0;
          two_nxt          = 1'b0;
          lend_nxt         = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int l = 0; l < 4; l++) begin
        if (mem_be[l]) begin
          blk_mem_r[mem_waddr][l*8 +: 8] <= mem_wdata[l*8 +: 8];
        end
      end
    end
    rdata_r <= blk_mem_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      chain_r <= CHAIN_INIT;
      rnd_r   <= '0;
      widx_r  <= '0;
      last_r  <= 1'b0;
      two_r   <= 1'b0;
      lend_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      chain_r <= chain_nxt;
      rnd_r   <= rnd_nxt;
      widx_r  <= widx_nxt;
      last_r  <= last_nxt;
      two_r   <= two_nxt;
      lend_r  <= lend_nxt;
      out_v_r <= out_v_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    out_r <= out_nxt;
  end

endmodule

>>> sv/md5_hash_engine_top.sv
// Every 64th byte starts a compression (prefetch, 64 rounds through the single round
// unit, chaining add). After the last transaction the block is padded and compressed;
// an extra pad block follows when fill >= 56 bytes, and a block that the last byte
// closes is compressed before the padding starts.
// Reset (rst_n low, synchronous): queues empty, chaining words at their initial values,
// byte count zero; the block buffer is not cleared, padding overwrites every unused word.
module md5_hash_engine_top #(
  parameter int QDEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  md5_pkg::md5_in_t  in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output md5_pkg::md5_out_t out_data
);
  import md5_pkg::*;

  // front: one holding register, drops transactions carrying neither byte nor end mark
  logic     f_push;
  md5_cmd_t f_cmd;
  logic     q_full;

  // queue between front and back so byte transactions keep landing during a compression
  logic     q_valid;
  logic     q_pop;
  md5_cmd_t q_cmd;

  md5_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (f_push),
    .q_cmd   (f_cmd),
    .q_full  (q_full)
  );

  md5_cmdq #(
    .DEPTH (QDEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_cmd)
  );

  // back: byte buffer, padding sequencer, round unit and the single-entry result register
  md5_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

>>> sv/md5_checker.sv
module md5_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_push,
  input logic              in_full,
  input md5_pkg::md5_in_t  in_data,
  input logic              out_empty,
  input logic              out_pop,
  input md5_pkg::md5_out_t out_data
);
  import md5_pkg::*;

  // nothing to deliver right after reset
  a_empty_after_rst: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // input side open right after reset
  a_ready_after_rst: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full right after reset");

  // a popped digest is never replaced in the cycle after the pop
  a_no_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop) |=> out_empty)
    else $error("new digest without a free cycle after pop");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting digest changed or dropped");

endmodule

bind md5_hash_engine_top md5_checker u_chk (.*);
